@@ hdl/lr_pkg.sv @@
// Shared types, constants and helpers for the line rasterizer.
// No dependencies; used by every module under hdl/.
package lr_pkg;

    localparam int SCREEN_W = 640;
    localparam int SCREEN_H = 320;

    localparam int XW = 10;
    localparam int YW = 9;
    localparam int CW = 32;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // registered input item, coordinates already clamped to the screen
    typedef struct packed {
        logic          mode;
        logic [XW-1:0] start_x;
        logic [YW-1:0] start_y;
        logic [XW-1:0] end_x;
        logic [YW-1:0] end_y;
    } t_item;

    // one emitted pixel
    typedef struct packed {
        logic [XW-1:0] pixel_x;
        logic [YW-1:0] pixel_y;
        logic [CW-1:0] pixel_color;
        logic          last_pixel;
    } t_pixel;

    function automatic logic [XW-1:0] clamp_x(input logic [XW-1:0] v);
        return (int'(v) >= SCREEN_W) ? XW'(SCREEN_W - 1) : v;
    endfunction

    function automatic logic [YW-1:0] clamp_y(input logic [YW-1:0] v);
        return (int'(v) >= SCREEN_H) ? YW'(SCREEN_H - 1) : v;
    endfunction

endpackage

@@ hdl/lr_input_reg.sv @@
// Input register of the line rasterizer: takes items off the slave stream
// and clamps the endpoints. Depends on lr_pkg.
module lr_input_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [39:0]            i_s_axis_tdata,
    input  logic                   i_s_axis_tuser,
    input  logic                   i_advance,
    output logic                   o_valid,
    output lr_pkg::t_item          o_item
);

    logic          r_valid;
    lr_pkg::t_item r_item;
    logic          w_take;

    assign o_s_axis_tready = !r_valid || i_advance;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.mode    <= i_s_axis_tuser;
            r_item.start_x <= lr_pkg::clamp_x(i_s_axis_tdata[9:0]);
            r_item.start_y <= lr_pkg::clamp_y(i_s_axis_tdata[18:10]);
            r_item.end_x   <= lr_pkg::clamp_x(i_s_axis_tdata[28:19]);
            r_item.end_y   <= lr_pkg::clamp_y(i_s_axis_tdata[37:29]);
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hdl/lr_core.sv @@
// Line state and step logic: load latches deltas and directions, a step
// emits the current pixel and advances the error term. Depends on lr_pkg.
module lr_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [lr_pkg::CW-1:0]  i_cfg_data,
    input  logic                   i_advance,
    input  lr_pkg::t_item          i_item,
    output logic                   o_res_valid,
    output lr_pkg::t_pixel         o_res
);

    localparam int XW = lr_pkg::XW;
    localparam int YW = lr_pkg::YW;

    logic [lr_pkg::CW-1:0] r_color;
    logic                  r_busy, n_busy;
    logic [XW-1:0]         r_cur_x, n_cur_x;
    logic [YW-1:0]         r_cur_y, n_cur_y;
    logic [XW-1:0]         r_major, n_major;
    logic [XW-1:0]         r_minor, n_minor;
    logic [XW-1:0]         r_err, n_err;
    logic [XW-1:0]         r_left, n_left;
    logic                  r_steep, n_steep;
    logic                  r_xneg, n_xneg;
    logic                  r_yneg, n_yneg;

    logic                  w_xneg, w_yneg, w_steep, w_last, w_minor_step;
    logic [XW-1:0]         w_dx, w_dy, w_major;
    logic [XW:0]           w_sum;
    logic [XW-1:0]         w_x_mv;
    logic [YW-1:0]         w_y_mv;

    always_comb begin
        // load path
        w_xneg  = i_item.end_x < i_item.start_x;
        w_yneg  = i_item.end_y < i_item.start_y;
        w_dx    = w_xneg ? (i_item.start_x - i_item.end_x) : (i_item.end_x - i_item.start_x);
        w_dy    = XW'(w_yneg ? (i_item.start_y - i_item.end_y)
                             : (i_item.end_y - i_item.start_y));
        w_steep = w_dy > w_dx;
        w_major = w_steep ? w_dy : w_dx;

        // step path
        w_last       = r_left <= XW'(1);
        w_sum        = {1'b0, r_err} + {1'b0, r_minor};
        w_minor_step = w_sum >= {1'b0, r_major};
        w_x_mv       = r_xneg ? (r_cur_x - XW'(1)) : (r_cur_x + XW'(1));
        w_y_mv       = r_yneg ? (r_cur_y - YW'(1)) : (r_cur_y + YW'(1));

        n_busy  = r_busy;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_major = r_major;
        n_minor = r_minor;
        n_err   = r_err;
        n_left  = r_left;
        n_steep = r_steep;
        n_xneg  = r_xneg;
        n_yneg  = r_yneg;

        if (i_item.mode == lr_pkg::MODE_LOAD) begin
            n_xneg  = w_xneg;
            n_yneg  = w_yneg;
            n_steep = w_steep;
            n_major = w_major;
            n_minor = w_steep ? w_dx : w_dy;
            n_err   = '0;
            n_left  = w_major + XW'(1);
            n_cur_x = i_item.start_x;
            n_cur_y = i_item.start_y;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            if (w_last) begin
                n_left = '0;
                n_busy = 1'b0;
            end else begin
                n_err  = w_minor_step ? XW'(w_sum - {1'b0, r_major}) : XW'(w_sum);
                n_left = r_left - XW'(1);
                if (r_steep) begin
                    n_cur_y = w_y_mv;
                    if (w_minor_step) n_cur_x = w_x_mv;
                end else begin
                    n_cur_x = w_x_mv;
                    if (w_minor_step) n_cur_y = w_y_mv;
                end
            end
        end
    end

    assign o_res_valid       = (i_item.mode == lr_pkg::MODE_STEP) && r_busy;
    assign o_res.pixel_x     = r_cur_x;
    assign o_res.pixel_y     = r_cur_y;
    assign o_res.pixel_color = r_color;
    assign o_res.last_pixel  = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= '0;
        end else if (i_cfg_valid) begin
            r_color <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_major <= '0;
            r_minor <= '0;
            r_err   <= '0;
            r_left  <= '0;
            r_steep <= 1'b0;
            r_xneg  <= 1'b0;
            r_yneg  <= 1'b0;
        end else if (i_advance) begin
            r_busy  <= n_busy;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_major <= n_major;
            r_minor <= n_minor;
            r_err   <= n_err;
            r_left  <= n_left;
            r_steep <= n_steep;
            r_xneg  <= n_xneg;
            r_yneg  <= n_yneg;
        end
    end

endmodule

@@ hdl/lr_out_reg.sv @@
// Result register of the line rasterizer, driving the master stream.
// Depends on lr_pkg.
module lr_out_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  lr_pkg::t_pixel         i_res,
    output logic                   o_free,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [55:0]            o_m_axis_tdata,
    output logic                   o_m_axis_tlast
);

    logic           r_valid;
    lr_pkg::t_pixel r_res;

    assign o_free = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {5'b0, r_res.pixel_color, r_res.pixel_y, r_res.pixel_x};
    assign o_m_axis_tlast  = r_res.last_pixel;

endmodule

@@ hdl/line_rasterizer.sv @@
// Top level of the line rasterizer.
// Depends on lr_pkg, lr_input_reg, lr_core and lr_out_reg.
//
// Usage:
//   Slave stream carries commands. tuser = 0 loads a line from the start and
//   end points in tdata; tuser = 1 asks for the next pixel of that line.
//   A load emits nothing and replaces any line in progress. A pixel request
//   with no line active is swallowed without a result.
//   Master stream carries pixels: coordinates plus the line color, tlast on
//   the final pixel of the line.
//   The config channel writes the line color; it is always ready and should
//   only be written while no command is in flight.
//   Endpoints beyond the screen are clamped to the right or bottom edge.
// Timing:
//   One command per cycle while the master side is not stalled. A command
//   accepted into the input register is stepped when it advances, and its
//   pixel is loaded into the result register, which drives the master side.
//   The rate is set by the combinational add/compare of the error term in lr_core.
// Stall / reset:
//   When the master side stalls, the pixel holds in the result register,
//   one more command waits in the input register, then tready drops.
//   Reset (synchronous, active low) clears the line state, both stage
//   valids and the color register.
module line_rasterizer (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [9:0] start_x, [18:10] start_y, [28:19] end_x, [37:29] end_y, [39:38] zero
    input  logic [39:0]            i_s_axis_tdata,
    // [0] mode
    input  logic                   i_s_axis_tuser,
    // master stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [9:0] pixel_x, [18:10] pixel_y, [50:19] pixel_color, [55:51] zero
    output logic [55:0]            o_m_axis_tdata,
    output logic                   o_m_axis_tlast,
    // config write: line color
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [lr_pkg::CW-1:0]  i_cfg_data
);

    logic           w_in_valid;
    lr_pkg::t_item  w_item;
    logic           w_out_free;
    logic           w_advance;
    logic           w_res_valid;
    lr_pkg::t_pixel w_res;

    // the step stage moves whenever it holds a command and the result
    // register can take whatever that command produces
    assign w_advance   = w_in_valid && w_out_free;
    assign o_cfg_ready = 1'b1;

    lr_input_reg u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_advance       (w_advance),
        .o_valid         (w_in_valid),
        .o_item          (w_item)
    );

    lr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (w_advance),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    lr_out_reg u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_advance && w_res_valid),
        .i_res           (w_res),
        .o_free          (w_out_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
